/* hw/rtl/multi_task_window_watchdog_defines.svh */
// ----------------------------------------------------------------------------
// Watchdog assertion macros
// Shared concurrent assertion forms for the windowed task watchdog.
// ----------------------------------------------------------------------------
`ifndef MULTI_TASK_WINDOW_WATCHDOG_DEFINES_SVH
`define MULTI_TASK_WINDOW_WATCHDOG_DEFINES_SVH

// same-cycle implication
`define MTWW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MTWW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/mtww_pkg.sv */
// ----------------------------------------------------------------------------
// Watchdog package
// Types, constants and helpers of the windowed task watchdog.
// ----------------------------------------------------------------------------
`default_nettype none

package mtww_pkg;

   localparam int unsigned NumTasks = 3;
   localparam int unsigned CntWidth = 10;
   localparam int unsigned IdWidth  = 3;
   localparam int unsigned IdxWidth = 3;

   localparam logic [CntWidth-1:0] CntMax = '1;

   localparam logic [CntWidth-1:0] RstTask0Lower = 10'd0;
   localparam logic [CntWidth-1:0] RstTask0Upper = 10'd0;
   localparam logic [CntWidth-1:0] RstTask1Lower = 10'd1;
   localparam logic [CntWidth-1:0] RstTask1Upper = 10'd12;
   localparam logic [CntWidth-1:0] RstTask2Lower = 10'd0;
   localparam logic [CntWidth-1:0] RstTask2Upper = 10'd0;
   localparam logic [CntWidth-1:0] RstKickLimit  = 10'd300;

   typedef enum logic {
      CMD_KICK = 1'b0,
      CMD_TICK = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      CAUSE_NONE     = 2'd0,
      CAUSE_OVERFLOW = 2'd1,
      CAUSE_BOUNDS   = 2'd2
   } cause_type;

   typedef enum logic [IdxWidth-1:0] {
      REG_TASK0_LOWER = 3'd0,
      REG_TASK0_UPPER = 3'd1,
      REG_TASK1_LOWER = 3'd2,
      REG_TASK1_UPPER = 3'd3,
      REG_TASK2_LOWER = 3'd4,
      REG_TASK2_UPPER = 3'd5,
      REG_KICK_LIMIT  = 3'd6
   } csr_index_type;

   typedef logic [CntWidth-1:0] count_type;

   typedef struct packed {
      logic                  reset_request;
      cause_type             cause;
      logic [NumTasks-1:0]   fail_mask;
   } result_type;

   function automatic count_type sat_inc(input count_type v);
      return (v == CntMax) ? v : v + count_type'(1);
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/mtww_if.sv */
// ----------------------------------------------------------------------------
// Watchdog channel interfaces
// Valid/ready channels for watchdog commands and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface mtww_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [2:0] task_id;

   modport source (output valid, output command, output task_id, input ready);
   modport sink   (input valid, input command, input task_id, output ready);
endinterface

interface mtww_rsp_if;
   logic       valid;
   logic       ready;
   logic       reset_request;
   logic [1:0] cause;
   logic [2:0] fail_mask;

   modport source (output valid, output reset_request, output cause, output fail_mask,
                   input ready);
   modport sink   (input valid, input reset_request, input cause, input fail_mask,
                   output ready);
endinterface

`default_nettype wire

/* hw/rtl/multi_task_window_watchdog.sv */
// A command's result goes to the result register, or to the skid entry when rsp_chan stalls.
// Throughput: one command per cycle while the skid entry is empty; counter updates and compares are combinational.
// A two-entry output stage (result register plus skid) keeps req_chan ready
// for one more transfer while a result waits on rsp_chan.
// Reset (synchronous, active high) clears all counters, empties the output
// stage and loads the bound and limit registers with their defaults.
// ----------------------------------------------------------------------------
// Windowed task watchdog
// Counts kicks from three tasks per period and checks them against windows
// at each period tick; raises a reset request on overflow or window miss.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multi_task_window_watchdog_defines.svh"

module multi_task_window_watchdog (
   input  wire logic                              clock,
   input  wire logic                              reset,
   mtww_req_if.sink                               req_chan,
   mtww_rsp_if.source                             rsp_chan,
   input  wire logic                              csr_we,
   input  wire logic [mtww_pkg::IdxWidth-1:0]     csr_index,
   input  wire logic [mtww_pkg::CntWidth-1:0]     csr_wdata
);

   mtww_pkg::count_type  lower_ff [mtww_pkg::NumTasks];
   mtww_pkg::count_type  upper_ff [mtww_pkg::NumTasks];
   mtww_pkg::count_type  limit_ff;

   mtww_pkg::count_type  cnt_ff  [mtww_pkg::NumTasks];
   mtww_pkg::count_type  cnt_in  [mtww_pkg::NumTasks];
   mtww_pkg::count_type  pending_ff;
   mtww_pkg::count_type  pending_in;

   mtww_pkg::result_type out_ff;
   mtww_pkg::result_type out_in;
   logic                 out_valid_ff;
   logic                 out_valid_in;
   mtww_pkg::result_type skid_ff;
   mtww_pkg::result_type skid_in;
   logic                 skid_valid_ff;
   logic                 skid_valid_in;

   mtww_pkg::result_type result;
   logic                 req_xfer;
   logic                 out_free;
   logic                 overflow;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff[0] <= mtww_pkg::RstTask0Lower;
         upper_ff[0] <= mtww_pkg::RstTask0Upper;
         lower_ff[1] <= mtww_pkg::RstTask1Lower;
         upper_ff[1] <= mtww_pkg::RstTask1Upper;
         lower_ff[2] <= mtww_pkg::RstTask2Lower;
         upper_ff[2] <= mtww_pkg::RstTask2Upper;
         limit_ff    <= mtww_pkg::RstKickLimit;
      end else if (csr_we) begin
         case (csr_index)
            mtww_pkg::REG_TASK0_LOWER: lower_ff[0] <= csr_wdata;
            mtww_pkg::REG_TASK0_UPPER: upper_ff[0] <= csr_wdata;
            mtww_pkg::REG_TASK1_LOWER: lower_ff[1] <= csr_wdata;
            mtww_pkg::REG_TASK1_UPPER: upper_ff[1] <= csr_wdata;
            mtww_pkg::REG_TASK2_LOWER: lower_ff[2] <= csr_wdata;
            mtww_pkg::REG_TASK2_UPPER: upper_ff[2] <= csr_wdata;
            mtww_pkg::REG_KICK_LIMIT:  limit_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_chan.ready = !skid_valid_ff;
   assign req_xfer       = req_chan.valid && !skid_valid_ff;
   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign overflow       = pending_ff >= limit_ff;

   // counter update and result
   always_comb begin
      result     = '{reset_request: 1'b0, cause: mtww_pkg::CAUSE_NONE, fail_mask: '0};
      pending_in = pending_ff;
      for (int t = 0; t < mtww_pkg::NumTasks; t++) begin
         cnt_in[t] = cnt_ff[t];
      end
      if (req_xfer) begin
         if (req_chan.command == mtww_pkg::CMD_KICK) begin
            if (overflow) begin
               result.reset_request = 1'b1;
               result.cause         = mtww_pkg::CAUSE_OVERFLOW;
               pending_in           = '0;
               for (int t = 0; t < mtww_pkg::NumTasks; t++) begin
                  cnt_in[t] = '0;
               end
            end else begin
               pending_in = mtww_pkg::sat_inc(pending_ff);
               for (int t = 0; t < mtww_pkg::NumTasks; t++) begin
                  if (req_chan.task_id == mtww_pkg::IdWidth'(t)) begin
                     cnt_in[t] = mtww_pkg::sat_inc(cnt_ff[t]);
                  end
               end
            end
         end else begin
            for (int t = 0; t < mtww_pkg::NumTasks; t++) begin
               result.fail_mask[t] = (cnt_ff[t] < lower_ff[t]) || (cnt_ff[t] > upper_ff[t]);
               cnt_in[t]           = '0;
            end
            pending_in = '0;
            if (result.fail_mask != '0) begin
               result.reset_request = 1'b1;
               result.cause         = mtww_pkg::CAUSE_BOUNDS;
            end
         end
      end
   end

   // result register with skid entry
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = result;
            out_valid_in = req_xfer;
         end
      end else if (req_xfer) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff    <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
         for (int t = 0; t < mtww_pkg::NumTasks; t++) begin
            cnt_ff[t] <= '0;
         end
      end else begin
         pending_ff    <= pending_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         for (int t = 0; t < mtww_pkg::NumTasks; t++) begin
            cnt_ff[t] <= cnt_in[t];
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.reset_request = out_ff.reset_request;
   assign rsp_chan.cause         = out_ff.cause;
   assign rsp_chan.fail_mask     = out_ff.fail_mask;

   `MTWW_ASSERT_NOW(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff,
      "skid entry held while result register empty")

   `MTWW_ASSERT_NEXT(a_tick_clears, clock, reset,
      req_xfer && req_chan.command == mtww_pkg::CMD_TICK,
      pending_ff == '0 && cnt_ff[0] == '0 && cnt_ff[1] == '0 && cnt_ff[2] == '0,
      "counters not cleared after tick")

   `MTWW_ASSERT_NEXT(a_overflow_clears, clock, reset,
      req_xfer && req_chan.command == mtww_pkg::CMD_KICK && overflow,
      pending_ff == '0 && cnt_ff[0] == '0 && cnt_ff[1] == '0 && cnt_ff[2] == '0,
      "counters not cleared after overflow")

   `MTWW_ASSERT_NOW(a_quiet_result, clock, reset,
      out_valid_ff && out_ff.cause == mtww_pkg::CAUSE_NONE,
      !out_ff.reset_request && out_ff.fail_mask == '0,
      "result without cause carries a request or failure")

   `MTWW_ASSERT_NEXT(a_full_stage_stalls, clock, reset,
      skid_valid_ff && !rsp_chan.ready,
      skid_valid_ff && $stable(skid_ff),
      "skid entry lost while output stalled")

endmodule

`default_nettype wire
